/* hw/rtl/aois_pkg.sv */
`timescale 1ns / 1ps

package aois_pkg;

	localparam int ANGLE_W = 16;
	localparam int OP_W = 2;
	localparam int STATUS_W = 2;
	localparam int USED_W = 7;

	localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;
	localparam logic [ANGLE_W-1:0] ANGLE_TOP = 16'hffff;

	typedef logic [ANGLE_W-1:0] angle_t;

	typedef enum logic [OP_W-1:0] {
		OP_SET   = 2'd0,
		OP_TEST  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_WIDE = 2'd2
	} status_t;

endpackage

/* hw/rtl/aois_req_if.sv */
`timescale 1ns / 1ps

interface aois_req_if
	import aois_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	angle_t            start_angle;
	angle_t            end_angle;

	modport source (output valid, output opcode, output start_angle, output end_angle,
		input ready);
	modport sink (input valid, input opcode, input start_angle, input end_angle,
		output ready);
endinterface

/* hw/rtl/aois_rsp_if.sv */
`timescale 1ns / 1ps

interface aois_rsp_if
	import aois_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                blocked;
	logic [STATUS_W-1:0] status;
	logic [USED_W-1:0]   entries_used;

	modport source (output valid, output blocked, output status, output entries_used,
		input ready);
	modport sink (input valid, input blocked, input status, input entries_used,
		output ready);
endinterface

/* hw/rtl/angular_occlusion_interval_set.sv */
`timescale 1ns / 1ps
// Set: merges the request, as 1 or 2 pieces, into the N stored ranges,
// one merge step per cycle over the table memory's single read port.
// Test: one stored range compared per cycle. Clear and other opcodes go straight to completion.
// One request in flight; ready rises in the same cycle as the result's valid, and a held result
// stalls completion. Reset empties the table (count zero); range storage is not cleared
// and needs no pass.
module angular_occlusion_interval_set
	import aois_pkg::*;
#(
	parameter int MAX_RANGES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	aois_req_if.sink    req,
	aois_rsp_if.source  rsp
);

	localparam int IDXW = $clog2(MAX_RANGES);
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int DEPTH = 2 << IDXW;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RANGES);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MERGE,
		S_TEST,
		S_DONE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   rd_idx_q;
	logic [CW-1:0]   rd_idx_d;
	logic [CW-1:0]   out_idx_q;
	logic [CW-1:0]   out_idx_d;
	logic            bank_q;
	logic            bank_d;
	angle_t          a1_q;
	angle_t          a2_q;
	logic            wrap_q;
	logic [1:0]      pc_q;
	logic            acc_v_q;
	angle_t          acc_lo_q;
	angle_t          acc_hi_q;
	logic            ovf_q;
	logic            ovf_d;
	logic            hit_q;
	logic            drop_d;
	logic            cova_q;
	logic            covb_q;
	logic            res_blocked_q;
	status_t         res_status_q;
	logic            rsp_valid_q;
	logic            rsp_blocked_q;
	status_t         rsp_status_q;
	logic [USED_W-1:0] rsp_used_q;

	logic [2*ANGLE_W-1:0] range_mem [DEPTH];
	logic [2*ANGLE_W-1:0] rdata_q;

	angle_t          span;
	logic            wide;
	logic            old_v;
	angle_t          old_lo;
	angle_t          old_hi;
	logic [1:0]      npieces;
	logic            pc_v;
	angle_t          pc_lo;
	angle_t          pc_hi;
	logic            any_v;
	logic            take_old;
	angle_t          item_lo;
	angle_t          item_hi;
	logic            joins;
	logic            emit;
	logic            wr_en;
	angle_t          a_hi;
	angle_t          b_lo;
	logic            rsp_free;

	always_comb begin
		span = req.end_angle - req.start_angle;
		wide = (span >= HALF_TURN);
		old_v = (rd_idx_q < count_q);
		old_lo = rdata_q[2*ANGLE_W-1:ANGLE_W];
		old_hi = rdata_q[ANGLE_W-1:0];
		npieces = wrap_q ? 2'd2 : 2'd1;
		pc_v = (pc_q < npieces);
		if (wrap_q && pc_q == 2'd0) begin
			pc_lo = '0;
			pc_hi = a2_q;
		end else if (wrap_q) begin
			pc_lo = a1_q;
			pc_hi = ANGLE_TOP;
		end else begin
			pc_lo = a1_q;
			pc_hi = a2_q;
		end
		any_v = old_v || pc_v;
		take_old = old_v && (!pc_v || old_lo <= pc_lo);
		item_lo = take_old ? old_lo : pc_lo;
		item_hi = take_old ? old_hi : pc_hi;
		joins = (item_lo <= acc_hi_q);
		emit = (state_q == S_MERGE) && acc_v_q && (!any_v || !joins);
		wr_en = emit && (out_idx_q < MAX_CNT);
		ovf_d = ovf_q || (emit && !wr_en);
		drop_d = ovf_d || (wrap_q && count_q == MAX_CNT && !hit_q);
		out_idx_d = out_idx_q + CW'(wr_en);
		a_hi = wrap_q ? ANGLE_TOP : a2_q;
		b_lo = wrap_q ? '0 : a1_q;
		rsp_free = !rsp_valid_q || rsp.ready;

		rd_idx_d = rd_idx_q;
		bank_d = bank_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					rd_idx_d = '0;
				end
			end
			S_MERGE: begin
				if (take_old) begin
					rd_idx_d = rd_idx_q + CW'(1);
				end
				if (!any_v && !drop_d) begin
					bank_d = ~bank_q;
				end
			end
			S_TEST: begin
				if (old_v) begin
					rd_idx_d = rd_idx_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			range_mem[{~bank_q, out_idx_q[IDXW-1:0]}] <= {acc_lo_q, acc_hi_q};
		end
		rdata_q <= range_mem[{bank_d, rd_idx_d[IDXW-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_idx_q <= '0;
			out_idx_q <= '0;
			bank_q <= 1'b0;
			a1_q <= '0;
			a2_q <= '0;
			wrap_q <= 1'b0;
			pc_q <= '0;
			acc_v_q <= 1'b0;
			acc_lo_q <= '0;
			acc_hi_q <= '0;
			ovf_q <= 1'b0;
			hit_q <= 1'b0;
			cova_q <= 1'b0;
			covb_q <= 1'b0;
			res_blocked_q <= 1'b0;
			res_status_q <= ST_OK;
			rsp_valid_q <= 1'b0;
			rsp_blocked_q <= 1'b0;
			rsp_status_q <= ST_OK;
			rsp_used_q <= '0;
		end else begin
			rd_idx_q <= rd_idx_d;
			bank_q <= bank_d;
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						a1_q <= req.start_angle;
						a2_q <= req.end_angle;
						wrap_q <= (req.start_angle > req.end_angle);
						pc_q <= '0;
						acc_v_q <= 1'b0;
						out_idx_q <= '0;
						ovf_q <= 1'b0;
						hit_q <= 1'b0;
						cova_q <= 1'b0;
						covb_q <= 1'b0;
						res_blocked_q <= 1'b0;
						res_status_q <= ST_OK;
						if ((req.opcode == OP_SET || req.opcode == OP_TEST) && wide) begin
							res_status_q <= ST_WIDE;
							state_q <= S_DONE;
						end else if (req.opcode == OP_SET) begin
							state_q <= S_MERGE;
						end else if (req.opcode == OP_TEST) begin
							state_q <= S_TEST;
						end else begin
							if (req.opcode == OP_CLEAR) begin
								count_q <= '0;
							end
							state_q <= S_DONE;
						end
					end
				end
				S_MERGE: begin
					out_idx_q <= out_idx_d;
					ovf_q <= ovf_d;
					if (any_v) begin
						if (take_old && old_hi >= a1_q) begin
							hit_q <= 1'b1;
						end
						if (!take_old) begin
							pc_q <= pc_q + 2'd1;
						end
						if (!acc_v_q || !joins) begin
							acc_lo_q <= item_lo;
							acc_hi_q <= item_hi;
							acc_v_q <= 1'b1;
						end else if (item_hi > acc_hi_q) begin
							acc_hi_q <= item_hi;
						end
					end else begin
						if (drop_d) begin
							res_status_q <= ST_FULL;
						end else begin
							count_q <= out_idx_d;
						end
						state_q <= S_DONE;
					end
				end
				S_TEST: begin
					if (old_v) begin
						if (old_lo <= a1_q && a_hi <= old_hi) begin
							cova_q <= 1'b1;
						end
						if (old_lo <= b_lo && a2_q <= old_hi) begin
							covb_q <= 1'b1;
						end
					end else begin
						res_blocked_q <= cova_q & covb_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_blocked_q <= res_blocked_q;
						rsp_status_q <= res_status_q;
						rsp_used_q <= USED_W'(count_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.blocked = rsp_blocked_q;
	assign rsp.status = rsp_status_q;
	assign rsp.entries_used = rsp_used_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("range count above capacity");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_MERGE) && (out_idx_q < MAX_CNT))
		else $error("table write outside capacity");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside completion");

	a_blocked_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_blocked_q |-> rsp_status_q == ST_OK)
		else $error("blocked reported with error status");

endmodule
